@@ src/stq_pkg.sv @@
// stq_pkg: shared types and codes for the sorted timer queue.
// No dependencies.
`default_nettype none
package stq_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/stq_cell.sv @@
// stq_cell: one queue slot of the sorted chain; shifts toward its neighbors.
// Depends on stq_pkg.
`default_nettype none
module stq_cell #(
  parameter int TIME_BITS  = 48,
  parameter int OWNER_BITS = 8
) (
  input  wire logic                  clk,
  input  wire stq_pkg::cell_ctl_t    ctl,
  input  wire logic                  occupied,
  input  wire logic [TIME_BITS-1:0]  new_time,
  input  wire logic [OWNER_BITS-1:0] new_owner,
  input  wire logic                  new_pres,
  input  wire logic                  left_le,
  input  wire logic [TIME_BITS-1:0]  left_time,
  input  wire logic [OWNER_BITS-1:0] left_owner,
  input  wire logic                  left_pres,
  input  wire logic [TIME_BITS-1:0]  right_time,
  input  wire logic [OWNER_BITS-1:0] right_owner,
  input  wire logic                  right_pres,
  output logic                       le,
  output logic [TIME_BITS-1:0]       time_q,
  output logic [OWNER_BITS-1:0]      owner_q,
  output logic                       pres_q
);

  logic [TIME_BITS-1:0]  time_r,  time_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic                  pres_r,  pres_nxt;

  // entry stays ahead of the new timer when due at or before it
  assign le = occupied && (time_r <= new_time);

  always_comb begin
    time_nxt  = time_r;
    owner_nxt = owner_r;
    pres_nxt  = pres_r;
    if (ctl.insert && !le) begin
      if (left_le) begin
        time_nxt  = new_time;
        owner_nxt = new_owner;
        pres_nxt  = new_pres;
      end else begin
        time_nxt  = left_time;
        owner_nxt = left_owner;
        pres_nxt  = left_pres;
      end
    end else if (ctl.pop) begin
      time_nxt  = right_time;
      owner_nxt = right_owner;
      pres_nxt  = right_pres;
    end
  end

  always_ff @(posedge clk) begin
    time_r  <= time_nxt;
    owner_r <= owner_nxt;
    pres_r  <= pres_nxt;
  end

  assign time_q  = time_r;
  assign owner_q = owner_r;
  assign pres_q  = pres_r;

endmodule
`default_nettype wire

@@ src/sorted_timer_queue.sv @@
// Sorted timer queue: a chain of slot cells kept in wake-up order.
// Expire: woken entries leave one per cycle while the output register is free,
// then the final word. Add: a sorted insert in the chain first, each wake one shift.
// One item in flight; the next is accepted once the final word sits in the output register.
// Reset (rst_n low, synchronous) empties the queue and drops any pending word.
// Depends on stq_pkg and stq_cell.
`default_nettype none
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48,
  parameter int OWNER_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic [TIME_BITS-1:0]  in_now_ms,
  input  wire logic [31:0]           in_sleep_ms,
  input  wire logic [OWNER_BITS-1:0] in_owner_id,
  input  wire logic                  in_owner_present,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_woken_valid,
  output logic [OWNER_BITS-1:0]      out_woken_owner,
  output logic                       out_woken_owner_present,
  output logic                       out_accepted,
  output logic                       out_queue_empty,
  output logic [TIME_BITS-1:0]       out_next_delay_ms,
  output logic                       out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  stq_pkg::cell_ctl_t ctl;

  logic                  op_r, acc_r, acc_nxt;
  logic [TIME_BITS-1:0]  now_r, wake_r;
  logic [OWNER_BITS-1:0] own_r;
  logic                  pres_r;
  logic [TIME_BITS:0]    wake_sum;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load, out_woken;
  logic [TIME_BITS-1:0]  delay_nxt;

  logic                  le      [QUEUE_DEPTH];
  logic                  occ     [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  c_time  [QUEUE_DEPTH];
  logic [OWNER_BITS-1:0] c_owner [QUEUE_DEPTH];
  logic                  c_pres  [QUEUE_DEPTH];

  logic accept, out_free, pop_cond;

  assign wake_sum = {1'b0, in_now_ms} + (TIME_BITS + 1)'(in_sleep_ms);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  l_le;
    logic [TIME_BITS-1:0]  l_time, r_time;
    logic [OWNER_BITS-1:0] l_owner, r_owner;
    logic                  l_pres, r_pres;

    assign occ[i] = count_r > CNT_W'(i);

    if (i == 0) begin : g_first
      assign l_le    = 1'b1;
      assign l_time  = '0;
      assign l_owner = '0;
      assign l_pres  = 1'b0;
    end else begin : g_mid
      assign l_le    = le[i-1];
      assign l_time  = c_time[i-1];
      assign l_owner = c_owner[i-1];
      assign l_pres  = c_pres[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign r_time  = '0;
      assign r_owner = '0;
      assign r_pres  = 1'b0;
    end else begin : g_next
      assign r_time  = c_time[i+1];
      assign r_owner = c_owner[i+1];
      assign r_pres  = c_pres[i+1];
    end

    stq_cell #(
      .TIME_BITS (TIME_BITS),
      .OWNER_BITS(OWNER_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .new_time   (wake_r),
      .new_owner  (own_r),
      .new_pres   (pres_r),
      .left_le    (l_le),
      .left_time  (l_time),
      .left_owner (l_owner),
      .left_pres  (l_pres),
      .right_time (r_time),
      .right_owner(r_owner),
      .right_pres (r_pres),
      .le         (le[i]),
      .time_q     (c_time[i]),
      .owner_q    (c_owner[i]),
      .pres_q     (c_pres[i])
    );
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pop_cond = ((op_r == stq_pkg::OP_EXPIRE) || acc_r) && (count_r != '0) &&
                    ((c_time[0] < now_r) ||
                     ((op_r == stq_pkg::OP_EXPIRE) && (c_time[0] == now_r)));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    ctl           = '0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    out_woken     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    delay_nxt     = '0;
    if ((count_r != '0) && (c_time[0] > now_r)) begin
      delay_nxt = c_time[0] - now_r;
    end
    case (state_r)
      stq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        acc_nxt  = 1'b0;
        if (in_valid) begin
          state_nxt = (in_operation == stq_pkg::OP_ADD) ? stq_pkg::ST_INSERT
                                                        : stq_pkg::ST_SCAN;
        end
      end
      stq_pkg::ST_INSERT: begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          acc_nxt = 1'b0;
        end else begin
          acc_nxt    = 1'b1;
          ctl.insert = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
        state_nxt = stq_pkg::ST_SCAN;
      end
      stq_pkg::ST_SCAN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (pop_cond) begin
            out_woken = 1'b1;
            ctl.pop   = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            state_nxt = stq_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stq_pkg::ST_IDLE;
      count_r     <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      now_r  <= in_now_ms;
      wake_r <= wake_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : wake_sum[TIME_BITS-1:0];
      own_r  <= in_owner_present ? in_owner_id : '0;
      pres_r <= in_owner_present;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_woken_valid         <= out_woken;
      out_woken_owner         <= out_woken ? c_owner[0] : '0;
      out_woken_owner_present <= out_woken ? c_pres[0] : 1'b0;
      out_accepted            <= out_woken ? 1'b0 : acc_r;
      out_queue_empty         <= out_woken ? 1'b0 : (count_r == '0);
      out_next_delay_ms       <= out_woken ? '0 : delay_nxt;
      out_last                <= !out_woken;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ src/stq_checker.sv @@
// stq_checker: port-level checks on the result channel of the timer queue.
// Bound to sorted_timer_queue; no other dependencies.
`default_nettype none
module stq_checker #(
  parameter int TIME_BITS  = 48,
  parameter int OWNER_BITS = 8
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_woken_valid,
  input wire logic [OWNER_BITS-1:0] out_woken_owner,
  input wire logic                  out_woken_owner_present,
  input wire logic                  out_accepted,
  input wire logic                  out_queue_empty,
  input wire logic [TIME_BITS-1:0]  out_next_delay_ms,
  input wire logic                  out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last) &&
      $stable(out_woken_owner) && $stable(out_next_delay_ms))
    else $error("result word changed while stalled");

  a_woken_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_woken_valid |-> !out_last && !out_accepted &&
      !out_queue_empty && (out_next_delay_ms == '0))
    else $error("woken word carries final fields");

  a_final_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_woken_valid && (out_woken_owner == '0) &&
      !out_woken_owner_present)
    else $error("final word carries woken fields");

  a_empty_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_queue_empty |-> (out_next_delay_ms == '0))
    else $error("empty queue reports a delay");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken before final word");

endmodule

bind sorted_timer_queue stq_checker #(
  .TIME_BITS (TIME_BITS),
  .OWNER_BITS(OWNER_BITS)
) u_stq_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_woken_valid        (out_woken_valid),
  .out_woken_owner        (out_woken_owner),
  .out_woken_owner_present(out_woken_owner_present),
  .out_accepted           (out_accepted),
  .out_queue_empty        (out_queue_empty),
  .out_next_delay_ms      (out_next_delay_ms),
  .out_last               (out_last)
);
`default_nettype wire
